[rtl/core/r2fft_pkg.sv]
`timescale 1ns / 1ps
package r2fft_pkg;

    // Default build values
    localparam int MAX_POINTS_DEF    = 64;
    localparam int SAMPLE_WIDTH_DEF  = 16;
    localparam int TWIDDLE_WIDTH_DEF = 16;

    // Bin growth over six stages
    localparam int GROWTH = 6;
    // Twiddle index width: W_64^k with k in 0..31
    localparam int KW     = 5;
    // Size code that selects 32 points
    localparam logic [2:0] SIZE_32 = 3'd5;
    localparam logic [2:0] SIZE_64 = 3'd6;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_RD_A,
        ST_RD_B,
        ST_MUL,
        ST_SUM,
        ST_WR_A,
        ST_WR_B,
        ST_OUT_RD,
        ST_OUT_CAP,
        ST_OUT_HOLD
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // store the accepted sample
        logic start;    // begin the transform
        logic rd_a;     // read upper butterfly leg
        logic rd_b;     // read lower leg, capture upper
        logic mul;      // form the four partial products
        logic sum;      // round the complex product
        logic wr_a;     // write a + p
        logic wr_b;     // write a - p, step the butterfly
        logic out_rd;   // read the next bin
        logic out_cap;  // load the output register
        logic out_adv;  // step the bin counter
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic block_last; // current sample closes the block
        logic xform_last; // current butterfly is the final one
        logic out_last;   // current bin is the final one
    } stat_t;

    // cos(pi*k/32) for k = 0..16 at 2^31
    function automatic logic [31:0] cos_q31(input logic [KW-1:0] idx);
        logic [31:0] c;
        unique case (idx)
            5'd0:    c = 32'd2147483648;
            5'd1:    c = 32'd2137142927;
            5'd2:    c = 32'd2106220352;
            5'd3:    c = 32'd2055013723;
            5'd4:    c = 32'd1984016189;
            5'd5:    c = 32'd1893911494;
            5'd6:    c = 32'd1785567396;
            5'd7:    c = 32'd1660027308;
            5'd8:    c = 32'd1518500250;
            5'd9:    c = 32'd1362349204;
            5'd10:   c = 32'd1193077991;
            5'd11:   c = 32'd1012316784;
            5'd12:   c = 32'd821806413;
            5'd13:   c = 32'd623381598;
            5'd14:   c = 32'd418953276;
            5'd15:   c = 32'd210490206;
            default: c = 32'd0;
        endcase
        return c;
    endfunction

endpackage

[rtl/core/r2fft_ram.sv]
`timescale 1ns / 1ps
module r2fft_ram #(
    parameter int WIDTH = 44,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

[rtl/core/r2fft_ctrl.sv]
`timescale 1ns / 1ps
module r2fft_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output r2fft_pkg::cmd_t   cmd,
    input  r2fft_pkg::stat_t  stat
);
    import r2fft_pkg::*;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid && stat.block_last) state_next = ST_RD_A;
            end
            ST_RD_A:    state_next = ST_RD_B;
            ST_RD_B:    state_next = ST_MUL;
            ST_MUL:     state_next = ST_SUM;
            ST_SUM:     state_next = ST_WR_A;
            ST_WR_A:    state_next = ST_WR_B;
            ST_WR_B:    state_next = stat.xform_last ? ST_OUT_RD : ST_RD_A;
            ST_OUT_RD:  state_next = ST_OUT_CAP;
            ST_OUT_CAP: state_next = ST_OUT_HOLD;
            ST_OUT_HOLD: begin
                if (m_ready) state_next = stat.out_last ? ST_LOAD : ST_OUT_RD;
            end
            default:    state_next = ST_LOAD;
        endcase
    end

    // Outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_ready   = 1'b1;
                cmd.load  = s_valid;
                cmd.start = s_valid && stat.block_last;
            end
            ST_RD_A:    cmd.rd_a    = 1'b1;
            ST_RD_B:    cmd.rd_b    = 1'b1;
            ST_MUL:     cmd.mul     = 1'b1;
            ST_SUM:     cmd.sum     = 1'b1;
            ST_WR_A:    cmd.wr_a    = 1'b1;
            ST_WR_B:    cmd.wr_b    = 1'b1;
            ST_OUT_RD:  cmd.out_rd  = 1'b1;
            ST_OUT_CAP: cmd.out_cap = 1'b1;
            ST_OUT_HOLD: begin
                m_valid     = 1'b1;
                cmd.out_adv = m_ready && !stat.out_last;
            end
            default: ;
        endcase
    end

    // A closing sample starts the butterflies right away
    a_close: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && stat.block_last |=> state_reg == ST_RD_A)
        else $error("block close did not start transform");

    // Input and output sides never open together
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and output both active");

    // Final bin transfer returns to loading
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && stat.out_last |=> s_ready)
        else $error("no return to load after last bin");
endmodule

[rtl/core/r2fft_dp.sv]
`timescale 1ns / 1ps
module r2fft_dp #(
    parameter int MAX_POINTS    = r2fft_pkg::MAX_POINTS_DEF,
    parameter int SAMPLE_WIDTH  = r2fft_pkg::SAMPLE_WIDTH_DEF,
    parameter int TWIDDLE_WIDTH = r2fft_pkg::TWIDDLE_WIDTH_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  r2fft_pkg::cmd_t                               cmd,
    output r2fft_pkg::stat_t                              stat,
    input  logic                                          cfg_we,
    input  logic [2:0]                                    cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0]                sample_re,
    input  logic signed [SAMPLE_WIDTH-1:0]                sample_im,
    output logic signed [SAMPLE_WIDTH+r2fft_pkg::GROWTH-1:0] bin_re,
    output logic signed [SAMPLE_WIDTH+r2fft_pkg::GROWTH-1:0] bin_im,
    output logic [5:0]                                    bin_index,
    output logic                                          last_bin
);
    import r2fft_pkg::*;

    localparam int AW   = $clog2(MAX_POINTS);
    localparam int HW   = AW - 1;
    localparam int BW   = SAMPLE_WIDTH + GROWTH;
    localparam int WW   = TWIDDLE_WIDTH + 1;
    localparam int MW   = BW + WW;
    localparam int SW   = MW + 1;
    localparam int PW   = BW + 2;
    localparam int AS   = BW + 3;
    localparam int TF   = TWIDDLE_WIDTH - 1;
    localparam int TS   = 32 - TWIDDLE_WIDTH;
    localparam int DW   = 2 * BW;
    localparam logic signed [AS-1:0] BIN_MAX = AS'((64'sd1 <<< (BW - 1)) - 1);
    localparam logic signed [AS-1:0] BIN_MIN = -BIN_MAX - AS'(1);
    localparam logic signed [SW-1:0] HALF_LSB = SW'(64'sd1 <<< (TF - 1));

    // Configuration and counters
    logic [2:0]   size_reg;
    logic         lg5_reg;
    logic [AW-1:0] load_cnt_reg;
    logic [2:0]   stage_reg;
    logic [HW-1:0] bfly_reg;
    logic [AW-1:0] out_reg;

    logic         lg5_now;
    logic [AW-1:0] nmask_now, nmask_x, idx, rev_full, load_addr;
    logic [HW-1:0] lowmask, jval;
    logic [AW-1:0] addr_a, addr_b, half_bit;
    logic [2:0]   lg_x;
    logic         bfly_stage_last;

    // Butterfly data path
    logic [DW-1:0]          rd_data, wr_data;
    logic [AW-1:0]          raddr, waddr;
    logic                   we, re;
    logic signed [BW-1:0]   a_re_reg, a_im_reg, b_re, b_im;
    logic signed [MW-1:0]   rr_reg, ii_reg, ri_reg, ir_reg;
    logic signed [PW-1:0]   pr_reg, pi_reg;
    logic signed [SW-1:0]   sum_re, sum_im;
    logic signed [SW-1:0]   sh_re, sh_im;
    logic signed [AS-1:0]   add_re, add_im, sub_re, sub_im;
    logic [KW-1:0]          kidx;
    logic [2:0]             tw_shift;
    logic signed [WW-1:0]   w_re, w_im;
    logic signed [BW-1:0]   obin_re_reg, obin_im_reg;
    logic [5:0]             oindex_reg;
    logic                   olast_reg;

    function automatic logic signed [WW-1:0] tw_mag(input logic [KW-1:0] i);
        logic [32:0] t;
        t = {1'b0, cos_q31(i)} + (33'd1 << (TS - 1));
        return WW'(t >> TS);
    endfunction

    function automatic logic signed [BW-1:0] sat(input logic signed [AS-1:0] x);
        logic signed [BW-1:0] r;
        if (x > BIN_MAX)      r = BW'(BIN_MAX);
        else if (x < BIN_MIN) r = BW'(BIN_MIN);
        else                  r = BW'(x);
        return r;
    endfunction

    // Active size: 32 points when forced by build or selected
    assign lg5_now   = (MAX_POINTS < 64) || (size_reg == SIZE_32);
    assign nmask_now = lg5_now ? AW'(31) : '1;
    assign nmask_x   = lg5_reg ? AW'(31) : '1;
    assign lg_x      = lg5_reg ? 3'd5 : 3'd6;

    // Arrival index and its bit-reversed address
    assign idx = load_cnt_reg & nmask_now;
    always_comb begin
        for (int i = 0; i < AW; i++) begin
            rev_full[i] = idx[AW-1-i];
        end
    end
    assign load_addr = lg5_now ? (rev_full >> (AW - 5)) : rev_full;

    // Butterfly legs: insert a zero bit at position stage-1
    assign lowmask  = ~({HW{1'b1}} << (stage_reg - 3'd1));
    assign jval     = bfly_reg & lowmask;
    assign half_bit = AW'(1) << (stage_reg - 3'd1);
    assign addr_a   = {bfly_reg & ~lowmask, 1'b0} | AW'(jval);
    assign addr_b   = addr_a | half_bit;
    assign bfly_stage_last = (bfly_reg == HW'(nmask_x >> 1));

    // Twiddle W_64^k with k = j * 64 / len
    assign tw_shift = 3'd6 - stage_reg;
    assign kidx     = KW'(jval) << tw_shift;
    always_comb begin
        if (kidx <= KW'(16)) begin
            w_re = tw_mag(kidx);
            w_im = -tw_mag(KW'(16) - kidx);
        end else begin
            w_re = -tw_mag(KW'(0) - kidx);
            w_im = -tw_mag(kidx - KW'(16));
        end
    end

    assign stat.block_last = (idx == nmask_now);
    assign stat.xform_last = (stage_reg == lg_x) && bfly_stage_last;
    assign stat.out_last   = (out_reg == nmask_x);

    // Size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_64;
        end else if (cfg_we) begin
            size_reg <= cfg_data;
        end
    end

    // Load count, stage and butterfly counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_cnt_reg <= '0;
            stage_reg    <= 3'd1;
            bfly_reg     <= '0;
            out_reg      <= '0;
            lg5_reg      <= 1'b0;
        end else begin
            if (cmd.load) begin
                load_cnt_reg <= stat.block_last ? '0 : idx + AW'(1);
            end
            if (cmd.start) begin
                stage_reg <= 3'd1;
                bfly_reg  <= '0;
                out_reg   <= '0;
                lg5_reg   <= lg5_now;
            end else if (cmd.wr_b) begin
                if (bfly_stage_last) begin
                    bfly_reg  <= '0;
                    if (!stat.xform_last) stage_reg <= stage_reg + 3'd1;
                end else begin
                    bfly_reg <= bfly_reg + HW'(1);
                end
            end
            if (cmd.out_adv) begin
                out_reg <= out_reg + AW'(1);
            end
        end
    end

    // Work memory ports
    assign b_re = rd_data[BW-1:0];
    assign b_im = rd_data[DW-1:BW];
    assign re   = cmd.rd_a || cmd.rd_b || cmd.out_rd;
    assign we   = cmd.load || cmd.wr_a || cmd.wr_b;

    always_comb begin
        priority if (cmd.rd_a)  raddr = addr_a;
        else if (cmd.rd_b)      raddr = addr_b;
        else                    raddr = out_reg;
    end

    always_comb begin
        priority if (cmd.wr_a) begin
            waddr   = addr_a;
            wr_data = {sat(add_im), sat(add_re)};
        end else if (cmd.wr_b) begin
            waddr   = addr_b;
            wr_data = {sat(sub_im), sat(sub_re)};
        end else begin
            waddr   = load_addr;
            wr_data = {BW'(sample_im), BW'(sample_re)};
        end
    end

    r2fft_ram #(
        .WIDTH(DW),
        .DEPTH(MAX_POINTS)
    ) u_ram (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wr_data),
        .re   (re),
        .raddr(raddr),
        .rdata(rd_data)
    );

    // Capture upper leg, then form products of lower leg and twiddle
    always_ff @(posedge aclk) begin
        if (cmd.rd_b) begin
            a_re_reg <= b_re;
            a_im_reg <= b_im;
        end
        if (cmd.mul) begin
            rr_reg <= MW'(b_re) * MW'(w_re);
            ii_reg <= MW'(b_im) * MW'(w_im);
            ri_reg <= MW'(b_re) * MW'(w_im);
            ir_reg <= MW'(b_im) * MW'(w_re);
        end
        if (cmd.sum) begin
            pr_reg <= PW'(sh_re);
            pi_reg <= PW'(sh_im);
        end
    end

    // Round the complex product to nearest, ties up
    assign sum_re = SW'(rr_reg) - SW'(ii_reg) + HALF_LSB;
    assign sum_im = SW'(ri_reg) + SW'(ir_reg) + HALF_LSB;
    assign sh_re  = sum_re >>> TF;
    assign sh_im  = sum_im >>> TF;

    // Butterfly sum and difference
    assign add_re = AS'(a_re_reg) + AS'(pr_reg);
    assign add_im = AS'(a_im_reg) + AS'(pi_reg);
    assign sub_re = AS'(a_re_reg) - AS'(pr_reg);
    assign sub_im = AS'(a_im_reg) - AS'(pi_reg);

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.out_cap) begin
            obin_re_reg <= b_re;
            obin_im_reg <= b_im;
            oindex_reg  <= 6'(out_reg);
            olast_reg   <= stat.out_last;
        end
    end

    assign bin_re    = obin_re_reg;
    assign bin_im    = obin_im_reg;
    assign bin_index = oindex_reg;
    assign last_bin  = olast_reg;

    // Stage counter stays within one to six
    a_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        stage_reg >= 3'd1 && stage_reg <= 3'd6)
        else $error("stage counter out of range");

    // Lower leg is written right after the upper leg
    a_wr_order: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_b |-> $past(cmd.wr_a))
        else $error("lower leg written out of order");

    // Legs of one butterfly differ by one bit
    a_legs: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_a |-> $countones(addr_a ^ addr_b) == 1)
        else $error("butterfly legs malformed");
endmodule

[rtl/core/radix2_fft_32_64.sv]
`timescale 1ns / 1ps
// Channel   Handshake                Payload
// s_        s_valid / s_ready        s_sample_re, s_sample_im
// m_        m_valid / m_ready        m_bin_re, m_bin_im, m_bin_index, m_last_bin
// cfg_      cfg_valid / cfg_ready    cfg_data (size_log2)
//
// Load accepts one sample per cycle. Each butterfly reads both legs, multiplies,
// rounds and writes both legs on the single shared butterfly unit and the one-read,
// one-write work RAM: N/2*log2(N) butterflies. Each bin is read, captured and held
// until taken. Input is held off from block close until the last bin transfers.
// Synchronous active-low reset; size resets to 64 points.
module radix2_fft_32_64 #(
    parameter int MAX_POINTS    = r2fft_pkg::MAX_POINTS_DEF,
    parameter int SAMPLE_WIDTH  = r2fft_pkg::SAMPLE_WIDTH_DEF,
    parameter int TWIDDLE_WIDTH = r2fft_pkg::TWIDDLE_WIDTH_DEF
) (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    input  logic                                             cfg_valid,
    output logic                                             cfg_ready,
    input  logic [2:0]                                       cfg_data,
    input  logic                                             s_valid,
    output logic                                             s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]                   s_sample_re,
    input  logic signed [SAMPLE_WIDTH-1:0]                   s_sample_im,
    output logic                                             m_valid,
    input  logic                                             m_ready,
    output logic signed [SAMPLE_WIDTH+r2fft_pkg::GROWTH-1:0] m_bin_re,
    output logic signed [SAMPLE_WIDTH+r2fft_pkg::GROWTH-1:0] m_bin_im,
    output logic [5:0]                                       m_bin_index,
    output logic                                             m_last_bin
);
    import r2fft_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Configuration is always taken
    assign cfg_ready = 1'b1;

    r2fft_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .cmd    (cmd),
        .stat   (stat)
    );

    r2fft_dp #(
        .MAX_POINTS   (MAX_POINTS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .TWIDDLE_WIDTH(TWIDDLE_WIDTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .sample_re(s_sample_re),
        .sample_im(s_sample_im),
        .bin_re   (m_bin_re),
        .bin_im   (m_bin_im),
        .bin_index(m_bin_index),
        .last_bin (m_last_bin)
    );
endmodule
